// ----- hdl/fdl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types and constants for the FAT directory entry lister.
// ----------------------------------------------------------------------------
package fdl_pkg;

    localparam int MAX_LISTED_DEFAULT = 1023;
    localparam int COUNT_W = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [COUNT_W-1:0] NAME_LIMIT_RESET = 10'd64;

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_START = 1'b1;

    localparam logic REPORT_CHAR = 1'b0;
    localparam logic REPORT_END = 1'b1;

    localparam logic [7:0] BYTE_END = 8'h00;
    localparam logic [7:0] BYTE_DELETED = 8'hE5;
    localparam logic [7:0] ATTR_LONG_NAME = 8'h0F;
    localparam logic [7:0] ATTR_VOLUME = 8'h08;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DOT = 8'h2E;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef struct packed {
        logic               report;
        logic               finished;
        logic [COUNT_W-1:0] count;
        logic [63:0]        base_name;
        logic [23:0]        extension;
        logic [3:0]         base_len;
        logic               has_ext;
        logic [1:0]         ext_len;
    } job_t;

endpackage

`default_nettype wire

// ----- hdl/fdl_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdl_front
// Accepts entries, classifies them, keeps the name count and finish flag,
// and queues one job for every entry that produces output.
// ----------------------------------------------------------------------------
module fdl_front
    import fdl_pkg::*;
#(
    parameter int MAX_LISTED = MAX_LISTED_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    input  wire logic [COUNT_W-1:0] cfg_data,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic               kind,
    input  wire logic [63:0]        base_name,
    input  wire logic [23:0]        extension,
    input  wire logic [7:0]         attributes,
    input  wire logic               queue_full,
    output logic                    push,
    output job_t                    push_job
);

    localparam logic [16:0] MaxL = 17'(MAX_LISTED);

    logic [COUNT_W-1:0] name_limit_reg;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               done_reg, done_next;
    logic               accept;
    logic [7:0]         b0;
    logic               skip;
    logic [16:0]        lim;
    logic [COUNT_W-1:0] count_inc;
    logic               done_inc;
    logic [3:0]         base_len;
    logic [1:0]         ext_len;
    logic               base_found;
    logic               ext_found;

    assign s_tready = !queue_full;
    assign accept = s_tvalid && s_tready;
    assign b0 = base_name[7:0];
    assign skip = (b0 == BYTE_DELETED) || (attributes == ATTR_LONG_NAME) ||
                  ((attributes & ATTR_VOLUME) != 8'h00);

    always_comb begin
        base_len = 4'd8;
        base_found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!base_found && base_name[8*i +: 8] == CHAR_SPACE) begin
                base_len = 4'(i);
                base_found = 1'b1;
            end
        end
        ext_len = 2'd3;
        ext_found = 1'b0;
        for (int j = 0; j < 3; j++) begin
            if (!ext_found && extension[8*j +: 8] == CHAR_SPACE) begin
                ext_len = 2'(j);
                ext_found = 1'b1;
            end
        end
    end

    always_comb begin
        lim = ({7'd0, name_limit_reg} > MaxL) ? MaxL : {7'd0, name_limit_reg};
        if (lim == 17'd0) begin
            lim = 17'd1;
        end
        count_inc = ({7'd0, count_reg} < MaxL) ? count_reg + 1'b1 : count_reg;
        done_inc = ({7'd0, count_inc} >= lim);
    end

    always_comb begin
        count_next = count_reg;
        done_next = done_reg;
        push = 1'b0;
        push_job.report = REPORT_CHAR;
        push_job.finished = done_inc;
        push_job.count = count_inc;
        push_job.base_name = base_name;
        push_job.extension = extension;
        push_job.base_len = base_len;
        push_job.has_ext = (extension[7:0] != CHAR_SPACE);
        push_job.ext_len = ext_len;
        if (accept) begin
            if (kind == KIND_START) begin
                count_next = '0;
                done_next = 1'b0;
            end else if (!done_reg) begin
                if (b0 == BYTE_END) begin
                    done_next = 1'b1;
                    push = 1'b1;
                    push_job.report = REPORT_END;
                    push_job.finished = 1'b1;
                    push_job.count = count_reg;
                end else if (!skip) begin
                    count_next = count_inc;
                    done_next = done_inc;
                    push = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_limit_reg <= NAME_LIMIT_RESET;
            count_reg <= '0;
            done_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                name_limit_reg <= cfg_data;
            end
            count_reg <= count_next;
            done_reg <= done_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fdl_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdl_queue
// Short job queue between the classifying front and the serializing back.
// ----------------------------------------------------------------------------
module fdl_queue
    import fdl_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire job_t push_job,
    output logic      full,
    input  wire logic pop,
    output job_t      pop_job,
    output logic      empty
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);

    job_t            entries [QUEUE_DEPTH];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW:0]   fill_reg;

    assign full = (fill_reg == (PtrW + 1)'(QUEUE_DEPTH));
    assign empty = (fill_reg == '0);
    assign pop_job = entries[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fdl_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fdl_back
// Holds one job and sends its characters, one per cycle while m_tready is high,
// ending with the terminator or the end report.
// ----------------------------------------------------------------------------
module fdl_back
    import fdl_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                queue_empty,
    input  wire job_t                queue_job,
    output logic                     pop,
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic                     report,
    output logic [7:0]               character,
    output logic                     last,
    output logic                     finished,
    output logic [COUNT_W-1:0]       names_listed
);

    job_t       job_reg;
    logic       valid_reg;
    logic [3:0] idx_reg;
    logic [3:0] last_idx;
    logic [3:0] ext_pos;
    logic       take;

    assign last_idx = job_reg.report ? 4'd0 :
                      job_reg.base_len + (job_reg.has_ext ? {2'd0, job_reg.ext_len} + 4'd1
                                                          : 4'd0);
    assign ext_pos = idx_reg - job_reg.base_len - 4'd1;
    assign take = valid_reg && m_tready;
    assign pop = !queue_empty && (!valid_reg || (take && idx_reg == last_idx));

    assign m_tvalid = valid_reg;
    assign report = job_reg.report;
    assign last = (idx_reg == last_idx);
    assign finished = job_reg.finished;
    assign names_listed = job_reg.count;

    always_comb begin
        character = CHAR_NUL;
        if (!job_reg.report) begin
            if (idx_reg < job_reg.base_len) begin
                character = job_reg.base_name[8*idx_reg[2:0] +: 8];
            end else if (job_reg.has_ext && idx_reg == job_reg.base_len) begin
                character = CHAR_DOT;
            end else if (job_reg.has_ext && idx_reg < last_idx) begin
                character = job_reg.extension[8*ext_pos[1:0] +: 8];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            job_reg <= queue_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                idx_reg <= '0;
            end else if (take) begin
                if (idx_reg == last_idx) begin
                    valid_reg <= 1'b0;
                end
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/fat_directory_entry_lister.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fat_directory_entry_lister
// Lists 8.3 names from FAT directory entries, one character per transaction.
// The first character of an entry is registered in the queue, then in the back job register.
// The back serializer gives one result per cycle while m_tready is high; an entry with an
// n-character name gives n + 1 results (at most 13), and skipped entries queue no job.
// A four-job queue lets the input keep running while results drain.
// Reset clears the count and finish flag, sets the limit to 64 and empties the queue.
// ----------------------------------------------------------------------------
module fat_directory_entry_lister
    import fdl_pkg::*;
#(
    parameter int MAX_LISTED = MAX_LISTED_DEFAULT
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [COUNT_W-1:0] cfg_data,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [95:0]        s_tdata,  // base_name, extension, attributes
    input  wire logic [0:0]         s_tuser,  // kind
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [23:0]             m_tdata,  // character, finished, names_listed, zero pad
    output logic [0:0]              m_tuser,  // report
    output logic                    m_tlast
);

    logic               queue_full;
    logic               queue_empty;
    logic               push;
    logic               pop;
    job_t               push_job;
    job_t               pop_job;
    logic [7:0]         character;
    logic               finished;
    logic [COUNT_W-1:0] names_listed;

    assign cfg_ready = 1'b1;
    assign m_tdata = {5'd0, names_listed, finished, character};

    fdl_front #(
        .MAX_LISTED(MAX_LISTED)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .kind       (s_tuser[0]),
        .base_name  (s_tdata[63:0]),
        .extension  (s_tdata[87:64]),
        .attributes (s_tdata[95:88]),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    fdl_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (pop),
        .pop_job  (pop_job),
        .empty    (queue_empty)
    );

    fdl_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .queue_empty  (queue_empty),
        .queue_job    (pop_job),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .report       (m_tuser[0]),
        .character    (character),
        .last         (m_tlast),
        .finished     (finished),
        .names_listed (names_listed)
    );

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FAT directory entry lister. Directory entries
// go in on the input stream with random gaps. A shadow copy of the name
// counter, the finish flag and the name limit predicts every 8.3 name
// character, terminator and end report. Results are checked in order while
// the output side stalls at random. Directed cases come first, then random
// listings under several name limits.
// ----------------------------------------------------------------------------
module tb_top;
    import fdl_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_CYCLES = 16;
    localparam int ITEM_TARGET = 430;

    typedef struct packed {
        logic               report;
        logic [7:0]         character;
        logic               last;
        logic               finished;
        logic [COUNT_W-1:0] names_listed;
    } name_char_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [95:0]        s_tdata = '0;  // base_name, extension, attributes
    logic [0:0]         s_tuser = '0;  // kind
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [23:0]        m_tdata;       // character, finished, names_listed, zero pad
    logic [0:0]         m_tuser;       // report
    logic               m_tlast;

    name_char_t         chars_due[$];
    name_char_t         seen_char;
    name_char_t         want_char;
    logic [COUNT_W-1:0] shadow_count = '0;
    logic               shadow_done = 1'b0;
    logic [COUNT_W-1:0] shadow_limit = NAME_LIMIT_RESET;
    int                 mismatch_count = 0;
    int                 items_sent = 0;
    int                 cycle_count = 0;
    int                 stall_left = 0;
    bit                 source_calm = 1'b0;
    bit                 sink_calm = 1'b0;

    fat_directory_entry_lister u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Shadow of the lister: updates the count and finish flag and queues the
    // characters that one accepted transaction must produce.
    function automatic void list_entry(logic kind, logic [63:0] base, logic [23:0] ext,
                                       logic [7:0] attr);
        logic [7:0] name_bytes [12];
        logic [7:0] c;
        int         n;
        int         lim;
        n = 0;
        if (kind == KIND_START) begin
            shadow_count = '0;
            shadow_done = 1'b0;
            return;
        end
        if (shadow_done) return;
        if (base[7:0] == BYTE_END) begin
            shadow_done = 1'b1;
            chars_due.push_back('{REPORT_END, CHAR_NUL, 1'b1, 1'b1, shadow_count});
            return;
        end
        if (base[7:0] == BYTE_DELETED || attr == ATTR_LONG_NAME || (attr & ATTR_VOLUME) != 0)
            return;
        for (int i = 0; i < 8; i++) begin
            c = base[8*i +: 8];
            if (c == CHAR_SPACE) break;
            name_bytes[n] = c;
            n++;
        end
        if (ext[7:0] != CHAR_SPACE) begin
            name_bytes[n] = CHAR_DOT;
            n++;
            for (int i = 0; i < 3; i++) begin
                c = ext[8*i +: 8];
                if (c == CHAR_SPACE) break;
                name_bytes[n] = c;
                n++;
            end
        end
        if (shadow_count < MAX_LISTED_DEFAULT) shadow_count++;
        lim = shadow_limit;
        if (lim > MAX_LISTED_DEFAULT) lim = MAX_LISTED_DEFAULT;
        if (lim == 0) lim = 1;
        if (shadow_count >= lim) shadow_done = 1'b1;
        for (int i = 0; i < n; i++)
            chars_due.push_back('{REPORT_CHAR, name_bytes[i], 1'b0, shadow_done, shadow_count});
        chars_due.push_back('{REPORT_CHAR, CHAR_NUL, 1'b1, shadow_done, shadow_count});
    endfunction

    function automatic logic [63:0] pack_base(string s);
        logic [63:0] b;
        b = {8{CHAR_SPACE}};
        for (int i = 0; i < s.len() && i < 8; i++) b[8*i +: 8] = s[i];
        return b;
    endfunction

    function automatic logic [23:0] pack_ext(string s);
        logic [23:0] e;
        e = {3{CHAR_SPACE}};
        for (int i = 0; i < s.len() && i < 3; i++) e[8*i +: 8] = s[i];
        return e;
    endfunction

    function automatic logic [7:0] name_char();
        string alphabet;
        alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-$~!";
        if ($urandom_range(0, 11) == 0) return 8'($urandom_range(0, 255));
        return alphabet[$urandom_range(0, alphabet.len() - 1)];
    endfunction

    function automatic logic [63:0] random_base();
        logic [63:0] b;
        int          len;
        b = {8{CHAR_SPACE}};
        len = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) b[8*i +: 8] = name_char();
        if (b[7:0] == BYTE_END || b[7:0] == BYTE_DELETED) b[7:0] = "A";
        return b;
    endfunction

    function automatic logic [23:0] random_ext();
        logic [23:0] e;
        int          len;
        e = {3{CHAR_SPACE}};
        len = $urandom_range(0, 3);
        for (int i = 0; i < len; i++) e[8*i +: 8] = name_char();
        return e;
    endfunction

    task automatic send_item(input logic kind, input logic [63:0] base, input logic [23:0] ext,
                             input logic [7:0] attr);
        int gap;
        gap = source_calm ? 0 : pick_gap();
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {attr, ext, base};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        list_entry(kind, base, ext, attr);
        items_sent++;
    endtask

    task automatic send_entry(input logic [63:0] base, input logic [23:0] ext,
                              input logic [7:0] attr);
        send_item(KIND_ENTRY, base, ext, attr);
    endtask

    task automatic send_start();
        send_item(KIND_START, {$urandom, $urandom}, 24'($urandom), 8'($urandom));
    endtask

    task automatic send_end_marker();
        logic [63:0] base;
        base = {$urandom, $urandom};
        base[7:0] = BYTE_END;
        send_item(KIND_ENTRY, base, 24'($urandom), 8'($urandom));
    endtask

    task automatic send_normal();
        logic [7:0] attr;
        attr = 8'($urandom) & ~ATTR_VOLUME;
        send_entry(random_base(), random_ext(), attr);
    endtask

    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (chars_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(input logic [COUNT_W-1:0] value);
        settle();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        shadow_limit = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_directed_names();
        logic [63:0] base;
        send_start();
        send_entry(pack_base("README"), pack_ext("TXT"), 8'h20);
        send_entry(pack_base("ABCDEFGH"), pack_ext("XYZ"), 8'h00);
        send_entry(pack_base("MAKEFILE"), pack_ext(""), 8'h01);
        send_entry(pack_base("A"), pack_ext("C"), 8'h10);
        send_entry(pack_base("SPLIT"), pack_ext("A B"), 8'h04);
        send_entry({64{1'b1}}, {24{1'b1}}, 8'hF7);
        send_entry(pack_base(""), pack_ext("X"), 8'h02);
        base = pack_base("ABXCD");
        base[23:16] = 8'h00;
        send_entry(base, pack_ext("Z"), 8'h07);
    endtask

    task automatic test_skipped_entries();
        logic [63:0] base;
        base = pack_base("GONE");
        base[7:0] = BYTE_DELETED;
        send_entry(base, pack_ext("TMP"), 8'h20);
        send_entry(pack_base("LONGNAME"), pack_ext("LFN"), ATTR_LONG_NAME);
        send_entry(pack_base("VOLUME"), pack_ext("LBL"), ATTR_VOLUME);
        send_entry(pack_base("ALLBITS"), pack_ext("SET"), 8'hFF);
        send_entry(pack_base("VOLARC"), pack_ext(""), 8'h18);
        send_entry(pack_base("AFTER"), pack_ext("SKP"), 8'h20);
    endtask

    task automatic test_end_marker();
        send_entry(64'h0, 24'h0, 8'h00);
        send_entry(pack_base("IGNORED"), pack_ext("TXT"), 8'h20);
        send_end_marker();
        send_start();
        send_entry(64'hFFFF_FFFF_FFFF_FF00, {24{1'b1}}, 8'hFF);
    endtask

    task automatic test_limit_extremes();
        write_limit(10'd1);
        send_start();
        send_normal();
        send_normal();
        send_end_marker();
        write_limit(10'd0);
        send_start();
        send_normal();
        send_normal();
        write_limit(10'd1023);
        send_start();
        repeat (3) send_normal();
        send_end_marker();
        write_limit(10'd3);
        send_start();
        repeat (4) send_normal();
    endtask

    task automatic run_listing(input int entries);
        logic [63:0] base;
        int          pick;
        send_start();
        repeat (entries) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
                send_normal();
            end else if (pick < 75) begin
                base = random_base();
                base[7:0] = BYTE_DELETED;
                send_entry(base, random_ext(), 8'($urandom) & ~ATTR_VOLUME);
            end else if (pick < 83) begin
                send_entry(random_base(), random_ext(), ATTR_LONG_NAME);
            end else if (pick < 90) begin
                send_entry(random_base(), random_ext(), 8'($urandom) | ATTR_VOLUME);
            end else begin
                send_entry({$urandom, $urandom}, 24'($urandom), 8'($urandom));
            end
        end
        if ($urandom_range(0, 9) < 6) send_end_marker();
    endtask

    task automatic test_random_listings();
        logic [COUNT_W-1:0] limits [6];
        int                 phase_end;
        limits[0] = 10'($urandom_range(1, 6));
        limits[1] = 10'd1023;
        limits[2] = 10'($urandom_range(7, 40));
        limits[3] = 10'd2;
        limits[4] = NAME_LIMIT_RESET;
        limits[5] = 10'($urandom_range(1, 1023));
        for (int p = 0; p < 6; p++) begin
            write_limit(limits[p]);
            source_calm = (p == 2);
            sink_calm = (p == 2) || (p == 4);
            phase_end = items_sent + (ITEM_TARGET - items_sent) / (6 - p);
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 9) < 8) begin
                    run_listing($urandom_range(0, 24));
                end else begin
                    send_item($urandom_range(0, 7) == 0, {$urandom, $urandom},
                              24'($urandom), 8'($urandom));
                end
            end
        end
        source_calm = 1'b0;
        sink_calm = 1'b0;
    endtask

    always @(negedge aclk) begin
        if (!sink_calm && stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (!sink_calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            seen_char = '{m_tuser[0], m_tdata[7:0], m_tlast, m_tdata[8], m_tdata[18:9]};
            if (chars_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $write("unexpected transaction: ");
                    $display("report=%0d char=%02h last=%0d fin=%0d cnt=%0d",
                             seen_char.report, seen_char.character, seen_char.last,
                             seen_char.finished, seen_char.names_listed);
                end
            end else begin
                want_char = chars_due.pop_front();
                if (seen_char !== want_char) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $write("mismatch: expected report=%0d char=%02h last=%0d ",
                               want_char.report, want_char.character, want_char.last);
                        $write("fin=%0d cnt=%0d, ",
                               want_char.finished, want_char.names_listed);
                        $write("got report=%0d char=%02h last=%0d ",
                               seen_char.report, seen_char.character, seen_char.last);
                        $display("fin=%0d cnt=%0d",
                                 seen_char.finished, seen_char.names_listed);
                    end
                end
            end
        end
    end

    initial begin
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_names();
        test_skipped_entries();
        test_end_marker();
        test_limit_extremes();
        test_random_listings();
        settle();
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- fat_directory_entry_lister.f -----
hdl/fdl_pkg.sv
hdl/fdl_front.sv
hdl/fdl_queue.sv
hdl/fdl_back.sv
hdl/fat_directory_entry_lister.sv
test/tb_top.sv
